FILE: rtl/splpin_pkg.sv
// ----------------------------------------------------------------------------
// splpin_pkg
// Types and constants shared by the sorted priority list with pinning.
// ----------------------------------------------------------------------------
package splpin_pkg;

  localparam int REQ_TYPE_W = 2;
  localparam int HANDLE_W   = 8;
  localparam int PRIO_W     = 4;
  localparam int AGE_W      = 16;
  localparam int POS_W      = 6;
  localparam int STATUS_W   = 2;
  localparam int CNT_OUT_W  = 7;
  localparam int CAP_W      = 7;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  localparam logic [REQ_TYPE_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_TYPE_W-1:0] REQ_REMOVE = 2'd1;
  localparam logic [REQ_TYPE_W-1:0] REQ_READ   = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_MISS = 2'd2;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_CMP,
    FSM_UPD
  } fsm_state_t;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic cmp_en;
    logic ins_mode;
    logic ins_we;
    logic rem_we;
  } cell_ctrl_t;

endpackage

FILE: rtl/splpin_if.sv
// ----------------------------------------------------------------------------
// splpin request / response channels
// Valid/ready channels carrying one request beat and one response beat.
// ----------------------------------------------------------------------------
interface splpin_req_if
  import splpin_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [REQ_TYPE_W-1:0] req_type;
  logic [HANDLE_W-1:0]   handle;
  logic [PRIO_W-1:0]     priority_req;
  logic [AGE_W-1:0]      entry_age;
  logic                  pinned;
  logic [POS_W-1:0]      position;

  modport source (
    output valid, req_type, handle, priority_req, entry_age, pinned, position,
    input  ready
  );
  modport sink (
    input  valid, req_type, handle, priority_req, entry_age, pinned, position,
    output ready
  );
endinterface

interface splpin_rsp_if
  import splpin_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [HANDLE_W-1:0]  read_handle;
  logic [PRIO_W-1:0]    read_priority;
  logic [CNT_OUT_W-1:0] entry_count;

  modport source (
    output valid, status, read_handle, read_priority, entry_count,
    input  ready
  );
  modport sink (
    input  valid, status, read_handle, read_priority, entry_count,
    output ready
  );
endinterface

FILE: rtl/splpin_cell.sv
// ----------------------------------------------------------------------------
// splpin_cell
// One list slot: holds an entry, flags a match against the request and
// loads from the request or a neighbour when the row shifts.
// ----------------------------------------------------------------------------
module splpin_cell
  import splpin_pkg::*;
#(
  parameter int IDX         = 0,
  parameter int HANDLE_BITS = 8,
  parameter int CW          = 7
) (
  input  logic                   clk,
  input  cell_ctrl_t             ctrl,
  input  logic [CW-1:0]          count,
  input  logic [HANDLE_BITS-1:0] new_handle,
  input  logic [PRIO_W-1:0]      new_prio,
  input  logic [AGE_W-1:0]       new_age,
  input  logic                   new_pin,
  input  logic [POS_W-1:0]       pos,
  input  logic                   ge_self,
  input  logic                   ge_left,
  input  logic [HANDLE_BITS-1:0] left_handle,
  input  logic [PRIO_W-1:0]      left_prio,
  input  logic [AGE_W-1:0]       left_age,
  input  logic                   left_pin,
  input  logic [HANDLE_BITS-1:0] right_handle,
  input  logic [PRIO_W-1:0]      right_prio,
  input  logic [AGE_W-1:0]       right_age,
  input  logic                   right_pin,
  output logic [HANDLE_BITS-1:0] handle_r,
  output logic [PRIO_W-1:0]      prio_r,
  output logic [AGE_W-1:0]       age_r,
  output logic                   pin_r,
  output logic                   hit_r,
  output logic                   sel_r
);

  localparam int PCW = (CW > POS_W) ? CW : POS_W;

  logic valid;
  logic is_tail;
  logic beats;
  logic hit_nxt;
  logic sel_nxt;

  assign valid   = CW'(IDX) < count;
  assign is_tail = CW'(IDX) == count;
  assign beats   = (new_prio > prio_r) || ((new_prio == prio_r) && (new_age >= age_r));
  assign sel_nxt = PCW'(pos) == PCW'(IDX);

  always_comb begin
    if (ctrl.ins_mode) begin
      hit_nxt = (valid && !pin_r && beats) || is_tail;
    end else begin
      hit_nxt = valid && (handle_r == new_handle);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.cmp_en) begin
      hit_r <= hit_nxt;
      sel_r <= sel_nxt;
    end
    if (ctrl.ins_we && ge_self) begin
      if (!ge_left) begin
        handle_r <= new_handle;
        prio_r   <= new_prio;
        age_r    <= new_age;
        pin_r    <= new_pin;
      end else begin
        handle_r <= left_handle;
        prio_r   <= left_prio;
        age_r    <= left_age;
        pin_r    <= left_pin;
      end
    end else if (ctrl.rem_we && ge_self) begin
      handle_r <= right_handle;
      prio_r   <= right_prio;
      age_r    <= right_age;
      pin_r    <= right_pin;
    end
  end

endmodule

FILE: rtl/sorted_priority_list_with_pinning_unit.sv
// ----------------------------------------------------------------------------
// sorted_priority_list_with_pinning_unit
// Ordered list of entries kept in a row of cells with insert, remove, read.
// ----------------------------------------------------------------------------
// Usage:
//   in_req  : request beats (insert, remove by handle, read by position).
//   out_rsp : one response beat per request: status, read data and the
//             entry count after the request.
//   cfg_we / cfg_wdata : write of capacity_limit; only while idle.
// Each request passes through a compare state in which every cell checks
// the request against its own entry, then an update state in which the
// first hit is found and, for a successful insert or remove, the row
// shifts one place by neighbour hand-off. The response is registered at
// the end of the update state; the next request can be accepted in that
// update state. If out_rsp is stalled, the update state waits until the
// response register is free; nothing is dropped.
// Reset empties the list and sets capacity_limit to 64. Entry storage is
// not cleared; slots beyond the count are never read.
// ----------------------------------------------------------------------------
module sorted_priority_list_with_pinning_unit
  import splpin_pkg::*;
#(
  parameter int ENTRIES     = 64,
  parameter int HANDLE_BITS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  splpin_req_if.sink         in_req,
  splpin_rsp_if.source       out_rsp,
  input  logic               cfg_we,
  input  logic [CAP_W-1:0]   cfg_wdata
);

  localparam int CW = $clog2(ENTRIES + 1);
  localparam int LW = (CW > CAP_W) ? CW : CAP_W;

  fsm_state_t state_r, state_nxt;

  logic [REQ_TYPE_W-1:0]  req_type_r;
  logic [HANDLE_BITS-1:0] req_handle_r;
  logic [PRIO_W-1:0]      req_prio_r;
  logic [AGE_W-1:0]       req_age_r;
  logic                   req_pin_r;
  logic [POS_W-1:0]       req_pos_r;

  logic [CW-1:0]    count_r, count_nxt;
  logic [CAP_W-1:0] cap_r;

  logic                 out_valid_r;
  logic [STATUS_W-1:0]  status_r, status_nxt;
  logic [HANDLE_W-1:0]  rd_handle_r, rd_handle_nxt;
  logic [PRIO_W-1:0]    rd_prio_r, rd_prio_nxt;
  logic [CNT_OUT_W-1:0] cnt_out_r;

  logic       in_fire;
  logic       out_free;
  logic       out_load;
  cell_ctrl_t ctrl;
  logic       do_ins;
  logic       do_rem;

  logic [HANDLE_BITS-1:0] c_handle [ENTRIES];
  logic [PRIO_W-1:0]      c_prio   [ENTRIES];
  logic [AGE_W-1:0]       c_age    [ENTRIES];
  logic                   c_pin    [ENTRIES];
  logic [ENTRIES-1:0]     hit_vec;
  logic [ENTRIES-1:0]     sel_vec;
  logic [ENTRIES-1:0]     ge_vec;
  logic [ENTRIES-1:0]     ge_left_vec;
  logic                   any_hit;
  logic                   full;
  logic                   rd_ok;
  logic [HANDLE_BITS-1:0] rd_h_or;
  logic [PRIO_W-1:0]      rd_p_or;

  assign in_fire  = in_req.valid && in_req.ready;
  assign out_free = !out_valid_r || out_rsp.ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FSM_IDLE: if (in_fire) state_nxt = FSM_CMP;
      FSM_CMP:  state_nxt = FSM_UPD;
      FSM_UPD: begin
        if (out_free) begin
          state_nxt = in_fire ? FSM_CMP : FSM_IDLE;
        end
      end
      default:  state_nxt = FSM_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_req.ready  = 1'b0;
    out_load      = 1'b0;
    ctrl.cmp_en   = 1'b0;
    ctrl.ins_mode = (req_type_r == REQ_INSERT);
    ctrl.ins_we   = 1'b0;
    ctrl.rem_we   = 1'b0;
    unique case (state_r)
      FSM_IDLE: in_req.ready = 1'b1;
      FSM_CMP:  ctrl.cmp_en = 1'b1;
      FSM_UPD: begin
        in_req.ready = out_free;
        out_load     = out_free;
        ctrl.ins_we  = out_free && do_ins;
        ctrl.rem_we  = out_free && do_rem;
      end
      default: ;
    endcase
  end

  // first hit and everything after it
  assign any_hit     = |hit_vec;
  assign ge_vec      = hit_vec | ((~hit_vec) + ENTRIES'(1));
  assign ge_left_vec = {ge_vec[ENTRIES-2:0], 1'b0};

  assign full  = (LW'(count_r) >= LW'(cap_r)) || (count_r >= CW'(ENTRIES));
  assign rd_ok = LW'(req_pos_r) < LW'(count_r);

  always_comb begin
    rd_h_or = '0;
    rd_p_or = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      rd_h_or = rd_h_or | ({HANDLE_BITS{sel_vec[i]}} & c_handle[i]);
      rd_p_or = rd_p_or | ({PRIO_W{sel_vec[i]}} & c_prio[i]);
    end
  end

  always_comb begin
    do_ins        = 1'b0;
    do_rem        = 1'b0;
    status_nxt    = STAT_MISS;
    rd_handle_nxt = '0;
    rd_prio_nxt   = '0;
    count_nxt     = count_r;
    unique case (req_type_r)
      REQ_INSERT: begin
        if (full) begin
          status_nxt = STAT_FULL;
        end else begin
          do_ins     = 1'b1;
          status_nxt = STAT_OK;
          count_nxt  = count_r + CW'(1);
        end
      end
      REQ_REMOVE: begin
        if (any_hit) begin
          do_rem     = 1'b1;
          status_nxt = STAT_OK;
          count_nxt  = count_r - CW'(1);
        end
      end
      REQ_READ: begin
        if (rd_ok) begin
          status_nxt    = STAT_OK;
          rd_handle_nxt = HANDLE_W'(rd_h_or);
          rd_prio_nxt   = rd_p_or;
        end
      end
      default: status_nxt = STAT_MISS;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      count_r     <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (out_load) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_type_r   <= in_req.req_type;
      req_handle_r <= HANDLE_BITS'(in_req.handle);
      req_prio_r   <= in_req.priority_req;
      req_age_r    <= in_req.entry_age;
      req_pin_r    <= in_req.pinned;
      req_pos_r    <= in_req.position;
    end
    if (out_load) begin
      status_r    <= status_nxt;
      rd_handle_r <= rd_handle_nxt;
      rd_prio_r   <= rd_prio_nxt;
      cnt_out_r   <= CNT_OUT_W'(count_nxt);
    end
  end

  assign out_rsp.valid         = out_valid_r;
  assign out_rsp.status        = status_r;
  assign out_rsp.read_handle   = rd_handle_r;
  assign out_rsp.read_priority = rd_prio_r;
  assign out_rsp.entry_count   = cnt_out_r;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic [HANDLE_BITS-1:0] l_handle, r_handle;
    logic [PRIO_W-1:0]      l_prio, r_prio;
    logic [AGE_W-1:0]       l_age, r_age;
    logic                   l_pin, r_pin;

    if (i == 0) begin : g_head
      assign l_handle = '0;
      assign l_prio   = '0;
      assign l_age    = '0;
      assign l_pin    = 1'b0;
    end else begin : g_mid_l
      assign l_handle = c_handle[i-1];
      assign l_prio   = c_prio[i-1];
      assign l_age    = c_age[i-1];
      assign l_pin    = c_pin[i-1];
    end

    if (i == ENTRIES - 1) begin : g_last
      assign r_handle = c_handle[i];
      assign r_prio   = c_prio[i];
      assign r_age    = c_age[i];
      assign r_pin    = c_pin[i];
    end else begin : g_mid_r
      assign r_handle = c_handle[i+1];
      assign r_prio   = c_prio[i+1];
      assign r_age    = c_age[i+1];
      assign r_pin    = c_pin[i+1];
    end

    splpin_cell #(
      .IDX         (i),
      .HANDLE_BITS (HANDLE_BITS),
      .CW          (CW)
    ) u_cell (
      .clk          (clk),
      .ctrl         (ctrl),
      .count        (count_r),
      .new_handle   (req_handle_r),
      .new_prio     (req_prio_r),
      .new_age      (req_age_r),
      .new_pin      (req_pin_r),
      .pos          (req_pos_r),
      .ge_self      (ge_vec[i]),
      .ge_left      (ge_left_vec[i]),
      .left_handle  (l_handle),
      .left_prio    (l_prio),
      .left_age     (l_age),
      .left_pin     (l_pin),
      .right_handle (r_handle),
      .right_prio   (r_prio),
      .right_age    (r_age),
      .right_pin    (r_pin),
      .handle_r     (c_handle[i]),
      .prio_r       (c_prio[i]),
      .age_r        (c_age[i]),
      .pin_r        (c_pin[i]),
      .hit_r        (hit_vec[i]),
      .sel_r        (sel_vec[i])
    );
  end

`ifndef NO_ASSERTIONS
  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.ins_we |=> count_r == CW'($past(count_r) + CW'(1)))
    else $error("insert did not grow the count by one");

  a_rem_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.rem_we |=> count_r == CW'($past(count_r) - CW'(1)))
    else $error("remove did not shrink the count by one");

  a_one_shift: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctrl.ins_we && ctrl.rem_we))
    else $error("row shifted both ways at once");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == FSM_UPD && !out_free) |=> (state_r == FSM_UPD) && $stable(count_r))
    else $error("update went ahead while response register was held");

  a_fire_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == FSM_CMP)
    else $error("accepted beat not followed by compare cycle");
`endif

endmodule

FILE: tb/splpin_list_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// splpin_list_checker
// Watches the request, response and capacity ports of the sorted priority
// list, keeps its own copy of the ordered list and compares every response
// beat, field by field, with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module splpin_list_checker
  import splpin_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  splpin_req_if            req_bus,
  splpin_rsp_if            rsp_bus,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata,
  output int               fail_count,
  output int               outstanding,
  output int               peak_fill,
  output int               full_rejects
);

  localparam int DEPTH      = 64;
  localparam int PRINT_CAP  = 40;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [HANDLE_W-1:0]  rd_handle;
    logic [PRIO_W-1:0]    rd_prio;
    logic [CNT_OUT_W-1:0] fill;
  } list_reply_t;

  logic [HANDLE_W-1:0] row_handle [DEPTH];
  logic [PRIO_W-1:0]   row_prio   [DEPTH];
  logic [AGE_W-1:0]    row_age    [DEPTH];
  logic                row_pin    [DEPTH];
  int                  fill_now;
  int                  cap_now;
  list_reply_t         replies_due [$];

  function automatic list_reply_t apply_request(
    input logic [REQ_TYPE_W-1:0] kind,
    input logic [HANDLE_W-1:0]   h,
    input logic [PRIO_W-1:0]     p,
    input logic [AGE_W-1:0]      a,
    input logic                  pin,
    input logic [POS_W-1:0]      pos
  );
    list_reply_t r;
    int limit;
    int at;
    int i;
    r = '0;
    r.status = STAT_MISS;
    case (kind)
      REQ_INSERT: begin
        limit = (cap_now > DEPTH) ? DEPTH : cap_now;
        if (fill_now >= limit) begin
          r.status = STAT_FULL;
        end else begin
          at = fill_now;
          // pinned entries never give way
          for (i = 0; i < fill_now && at == fill_now; i++) begin
            if (!row_pin[i] && (p > row_prio[i] || (p == row_prio[i] && a >= row_age[i])))
              at = i;
          end
          for (i = fill_now; i > at; i--) begin
            row_handle[i] = row_handle[i-1];
            row_prio[i]   = row_prio[i-1];
            row_age[i]    = row_age[i-1];
            row_pin[i]    = row_pin[i-1];
          end
          row_handle[at] = h;
          row_prio[at]   = p;
          row_age[at]    = a;
          row_pin[at]    = pin;
          fill_now++;
          r.status = STAT_OK;
        end
      end
      REQ_REMOVE: begin
        at = fill_now;
        for (i = 0; i < fill_now && at == fill_now; i++) begin
          if (row_handle[i] == h)
            at = i;
        end
        if (at < fill_now) begin
          for (i = at; i + 1 < fill_now; i++) begin
            row_handle[i] = row_handle[i+1];
            row_prio[i]   = row_prio[i+1];
            row_age[i]    = row_age[i+1];
            row_pin[i]    = row_pin[i+1];
          end
          fill_now--;
          r.status = STAT_OK;
        end
      end
      REQ_READ: begin
        if (int'(pos) < fill_now) begin
          r.status    = STAT_OK;
          r.rd_handle = row_handle[pos];
          r.rd_prio   = row_prio[pos];
        end
      end
      default: begin
      end
    endcase
    r.fill = CNT_OUT_W'(fill_now);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (fail_count < PRINT_CAP)
      $display("[%0t] MISMATCH %s", $time, msg);
    fail_count++;
  endtask

  task automatic compare_reply(input list_reply_t want);
    if (rsp_bus.status !== want.status)
      report_mismatch($sformatf("status: expected %0d got %0d", want.status, rsp_bus.status));
    if (rsp_bus.read_handle !== want.rd_handle)
      report_mismatch($sformatf("read_handle: expected %0d got %0d",
                                want.rd_handle, rsp_bus.read_handle));
    if (rsp_bus.read_priority !== want.rd_prio)
      report_mismatch($sformatf("read_priority: expected %0d got %0d",
                                want.rd_prio, rsp_bus.read_priority));
    if (rsp_bus.entry_count !== want.fill)
      report_mismatch($sformatf("entry_count: expected %0d got %0d",
                                want.fill, rsp_bus.entry_count));
  endtask

  always @(posedge clk) begin
    list_reply_t r;
    if (!rst_n) begin
      fill_now     = 0;
      cap_now      = int'(CAP_RESET);
      fail_count   = 0;
      peak_fill    = 0;
      full_rejects = 0;
      replies_due.delete();
    end else begin
      if (cfg_we)
        cap_now = int'(cfg_wdata);
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (replies_due.size() == 0)
          report_mismatch($sformatf("response beat with nothing outstanding, entry_count %0d",
                                    rsp_bus.entry_count));
        else
          compare_reply(replies_due.pop_front());
      end
      if (req_bus.valid && req_bus.ready) begin
        r = apply_request(req_bus.req_type, req_bus.handle, req_bus.priority_req,
                          req_bus.entry_age, req_bus.pinned, req_bus.position);
        if (r.status == STAT_FULL && req_bus.req_type == REQ_INSERT)
          full_rejects++;
        replies_due.push_back(r);
      end
      if (fill_now > peak_fill)
        peak_fill = fill_now;
    end
    outstanding <= replies_due.size();
  end

endmodule

FILE: tb/sorted_priority_list_with_pinning_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_priority_list_with_pinning_unit_test
// Drives insert, remove, read and undefined requests into the sorted list
// under several capacity settings, with bursty requests and a stalling
// response side; a checker beside the block predicts every response.
// ----------------------------------------------------------------------------
module sorted_priority_list_with_pinning_unit_test;
  import splpin_pkg::*;

  localparam logic [REQ_TYPE_W-1:0] REQ_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 60;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_wdata;

  int mismatches;
  int outstanding;
  int peak_fill;
  int full_rejects;

  int hold_asked = 0;
  int hold_done  = 0;

  int n_insert = 0;
  int n_remove = 0;
  int n_read   = 0;
  int n_other  = 0;
  int n_cfg    = 0;

  splpin_req_if in_req ();
  splpin_rsp_if out_rsp ();

  sorted_priority_list_with_pinning_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .out_rsp   (out_rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  splpin_list_checker list_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_bus      (in_req),
    .rsp_bus      (out_rsp),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (mismatches),
    .outstanding  (outstanding),
    .peak_fill    (peak_fill),
    .full_rejects (full_rejects)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d responses outstanding", cycles, outstanding);
    $display("sorted_priority_list_with_pinning_unit verification failed");
    $finish;
  end

  // response side: shifting stall patterns, plus long hold-offs on request
  initial begin : rsp_stall
    int mode;
    int tick;
    mode = 0;
    tick = 0;
    out_rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_asked != hold_done) begin
        out_rsp.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done++;
      end else begin
        tick++;
        if (tick % 40 == 0)
          mode = $urandom_range(0, 3);
        case (mode)
          0: out_rsp.ready <= 1'b1;
          1: out_rsp.ready <= ($urandom_range(0, 9) < 7);
          2: out_rsp.ready <= ($urandom_range(0, 9) < 3);
          default: out_rsp.ready <= (tick % 4 == 0);
        endcase
      end
    end
  end

  task automatic offer(
    input logic [REQ_TYPE_W-1:0] kind,
    input logic [HANDLE_W-1:0]   h,
    input logic [PRIO_W-1:0]     p,
    input logic [AGE_W-1:0]      a,
    input logic                  pin,
    input logic [POS_W-1:0]      pos
  );
    in_req.valid        <= 1'b1;
    in_req.req_type     <= kind;
    in_req.handle       <= h;
    in_req.priority_req <= p;
    in_req.entry_age    <= a;
    in_req.pinned       <= pin;
    in_req.position     <= pos;
    do @(posedge clk); while (!in_req.ready);
    case (kind)
      REQ_INSERT: n_insert++;
      REQ_REMOVE: n_remove++;
      REQ_READ:   n_read++;
      default:    n_other++;
    endcase
  endtask

  task automatic idle(input int cycles);
    in_req.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain();
    in_req.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we    <= 1'b0;
    n_cfg++;
  endtask

  task automatic random_item(input int ins_weight);
    int r;
    int span;
    int rest;
    logic [REQ_TYPE_W-1:0] kind;
    logic [HANDLE_W-1:0]   h;
    logic [PRIO_W-1:0]     p;
    logic [AGE_W-1:0]      a;
    logic                  pin;
    logic [POS_W-1:0]      pos;
    r    = $urandom_range(0, 99);
    span = 100 - ins_weight;
    rest = r - ins_weight;
    if (r < ins_weight)
      kind = REQ_INSERT;
    else if (rest < span * 45 / 100)
      kind = REQ_REMOVE;
    else if (rest < span * 92 / 100)
      kind = REQ_READ;
    else
      kind = REQ_UNUSED;
    h   = ($urandom_range(0, 9) < 7) ? HANDLE_W'($urandom_range(0, 15)) : HANDLE_W'($urandom);
    p   = PRIO_W'($urandom_range(0, 15));
    a   = ($urandom_range(0, 1) == 0) ? AGE_W'($urandom_range(0, 7)) : AGE_W'($urandom);
    pin = ($urandom_range(0, 99) < 15);
    pos = ($urandom_range(0, 9) < 7) ? POS_W'($urandom_range(0, 15)) : POS_W'($urandom);
    offer(kind, h, p, a, pin, pos);
  endtask

  task automatic run_phase(input logic [CAP_W-1:0] cap, input int ins_weight,
                           input int items, input bit long_hold);
    int sent;
    int burst;
    int gap;
    drain();
    set_capacity(cap);
    sent = 0;
    if (long_hold) begin
      // sender keeps offering back to back while the response side is held off
      hold_asked <= hold_asked + 1;
      for (int k = 0; k < 20; k++) begin
        random_item(ins_weight);
        sent++;
      end
    end
    while (sent < items) begin
      burst = $urandom_range(1, 10);
      for (int k = 0; k < burst && sent < items; k++) begin
        random_item(ins_weight);
        sent++;
      end
      if ($urandom_range(0, 3) == 0)
        gap = 0;
      else if ($urandom_range(0, 9) == 0)
        gap = $urandom_range(10, 30);
      else
        gap = $urandom_range(1, 4);
      if (gap > 0)
        idle(gap);
    end
  endtask

  initial begin : stimulus
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_wdata          <= '0;
    in_req.valid       <= 1'b0;
    in_req.req_type    <= REQ_INSERT;
    in_req.handle      <= '0;
    in_req.priority_req <= '0;
    in_req.entry_age   <= '0;
    in_req.pinned      <= 1'b0;
    in_req.position    <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list corner cases
    offer(REQ_REMOVE, 8'h00, 4'h0, 16'h0000, 1'b0, 6'd0);
    offer(REQ_READ,   8'h00, 4'h0, 16'h0000, 1'b0, 6'd0);
    offer(REQ_UNUSED, 8'hFF, 4'hF, 16'hFFFF, 1'b1, 6'd63);
    // ordering: ties on priority, pinned entries, duplicates, extremes
    offer(REQ_INSERT, 8'hFF, 4'hF, 16'hFFFF, 1'b0, 6'd0);
    offer(REQ_INSERT, 8'h00, 4'h0, 16'h0000, 1'b0, 6'd0);
    offer(REQ_INSERT, 8'h5A, 4'hF, 16'hFFFF, 1'b1, 6'd0);
    offer(REQ_INSERT, 8'hA5, 4'hF, 16'hFFFF, 1'b0, 6'd0);
    offer(REQ_INSERT, 8'hFF, 4'h7, 16'h0064, 1'b0, 6'd0);
    offer(REQ_INSERT, 8'h33, 4'h7, 16'h0063, 1'b0, 6'd0);
    offer(REQ_INSERT, 8'h0F, 4'h0, 16'hFFFF, 1'b0, 6'd0);
    for (int k = 0; k < 8; k++)
      offer(REQ_READ, 8'h00, 4'h0, 16'h0000, 1'b0, POS_W'(k));
    offer(REQ_READ,   8'h00, 4'h0, 16'h0000, 1'b0, 6'd63);
    offer(REQ_REMOVE, 8'hFF, 4'h0, 16'h0000, 1'b0, 6'd0);
    offer(REQ_REMOVE, 8'hC3, 4'h0, 16'h0000, 1'b0, 6'd0);
    offer(REQ_READ,   8'h00, 4'h0, 16'h0000, 1'b0, 6'd2);
    // capacity below the current count
    drain();
    set_capacity(7'd3);
    offer(REQ_INSERT, 8'h11, 4'hF, 16'hFFFF, 1'b0, 6'd0);

    run_phase(7'd127, 90, 90, 1'b0);
    run_phase(7'd64,  40, 70, 1'b1);
    run_phase(7'd0,   60, 20, 1'b0);
    run_phase(7'd5,   55, 60, 1'b0);
    run_phase(7'd1,   50, 30, 1'b0);
    run_phase(7'd64,  50, 70, 1'b0);
    run_phase(7'd64,  10, 40, 1'b0);
    drain();
    repeat (8) @(posedge clk);

    $display("covered %0d inserts, %0d removes, %0d reads, %0d undefined requests, %0d capacity writes",
             n_insert, n_remove, n_read, n_other, n_cfg);
    $display("list peaked at %0d entries; %0d inserts turned away as full", peak_fill, full_rejects);
    if (mismatches == 0 && outstanding == 0) begin
      $display("sorted_priority_list_with_pinning_unit verification clean");
    end else begin
      $display("sorted_priority_list_with_pinning_unit verification failed");
    end
    $finish;
  end

endmodule
